/* design/aes128_pkg.sv */
package aes128_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] CfgKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgKeyLow  = 1'b1;

  typedef logic [127:0] block_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] Rcon [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte n of the block sits at bits 127-8n
  function automatic logic [7:0] get_byte(block_t b, int n);
    return b[127-8*n -: 8];
  endfunction

  function automatic logic [7:0] gf_dbl(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t sub_shift(block_t s);
    block_t t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*c) -: 8] = Sbox[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_cols(block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      d0 = gf_dbl(a0);
      d1 = gf_dbl(a1);
      d2 = gf_dbl(a2);
      d3 = gf_dbl(a3);
      t[127-8*(4*c)   -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
      t[127-8*(4*c+1) -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
      t[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
      t[127-8*(4*c+3) -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
    end
    return t;
  endfunction

  function automatic block_t next_key(block_t k, logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {Sbox[w3[23:16]] ^ rc, Sbox[w3[15:8]], Sbox[w3[7:0]], Sbox[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

/* design/aes128_block_encrypt_core.sv */
// AES-128 block encryption core, fully unrolled round pipeline.
// Configuration: write key_high (index 0) and key_low (index 1) on the
// cfg channel (cfg_valid_i/cfg_ready_o); ready is always high. Write the
// key only while no block is in flight.
// Command: a block is taken at a clock edge with start high and busy
// low. busy is always low, so a new block may enter every cycle.
// Result: cipher_high_o/cipher_low_o are shown for one cycle with done_o
// high, once the block has passed through eleven registers (the initial
// key addition stage and one per round).
// Throughput is one block per cycle.
// Each stage carries its own round key, expanded alongside the data.
// Reset clears the key to zero and drops every valid bit in the pipe.
// The receiver cannot stall; every result beat is taken when shown.
module aes128_block_encrypt_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] plain_high_i,
  input  logic [63:0] plain_low_i,
  output logic        done_o,
  output logic [63:0] cipher_high_o,
  output logic [63:0] cipher_low_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [aes128_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import aes128_pkg::*;

  logic [63:0] key_high_q, key_low_q;
  logic        vld_q [NumRounds+1];
  block_t      st_q  [NumRounds+1];
  block_t      rk_q  [NumRounds+1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgKeyHigh: key_high_q <= cfg_data_i;
        CfgKeyLow:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NumRounds; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= start & ~busy;
      for (int i = 1; i <= NumRounds; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  block_t key0;
  assign key0 = {key_high_q, key_low_q};

  always_ff @(posedge clk_i) begin
    st_q[0] <= {plain_high_i, plain_low_i} ^ key0;
    rk_q[0] <= key0;
    for (int i = 1; i <= NumRounds; i++) begin
      rk_q[i] <= next_key(rk_q[i-1], Rcon[i-1]);
      if (i == NumRounds) begin
        st_q[i] <= sub_shift(st_q[i-1]) ^ next_key(rk_q[i-1], Rcon[i-1]);
      end else begin
        st_q[i] <= mix_cols(sub_shift(st_q[i-1])) ^ next_key(rk_q[i-1], Rcon[i-1]);
      end
    end
  end

  assign done_o        = vld_q[NumRounds];
  assign cipher_high_o = st_q[NumRounds][127:64];
  assign cipher_low_o  = st_q[NumRounds][63:0];

endmodule
